@@ rtl/core/alpha_edge_color_bleed_core_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ALPHA_EDGE_COLOR_BLEED_CORE_ASSERT_SVH
`define ALPHA_EDGE_COLOR_BLEED_CORE_ASSERT_SVH

// Same-cycle implication, disabled while dis is true.
`define AECB_ASSERT_NOW(label, clk, dis, a, b) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while dis is true.
`define AECB_ASSERT_NEXT(label, clk, dis, a, b) \
    label: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/aecb_pkg.sv @@
package aecb_pkg;

    localparam int MAX_SIDE_DEF = 64;
    localparam int PIX_W        = 32;
    localparam int CHAN_W       = 8;
    localparam int COORD_W      = 6;
    localparam int CFG_W        = 7;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_SIDE_RESET   = 7'd64;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Fetch order of a read: center first, then the four neighbors.
    typedef enum logic [2:0] {
        SLOT_C  = 3'd0,
        SLOT_XM = 3'd1,
        SLOT_XP = 3'd2,
        SLOT_YM = 3'd3,
        SLOT_YP = 3'd4
    } slot_t;

    typedef struct packed {
        logic  load_item;
        logic  rd_en;
        slot_t rd_slot;
        logic  cap_en;
        slot_t cap_slot;
        logic  load_out;
    } cmd_t;

    typedef struct packed {
        logic need_fetch;
    } stat_t;

endpackage

@@ rtl/core/aecb_ram.sv @@
module aecb_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4096
) (
    input  logic                                     aclk,
    input  logic                                     en,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [DATA_W-1:0]                        wdata,
    output logic [DATA_W-1:0]                        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

@@ rtl/core/aecb_ctrl.sv @@
module aecb_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  aecb_pkg::stat_t stat,
    output aecb_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_HOLD  = 3'b100
    } state_t;

    localparam logic [2:0] STEP_LAST = 3'd5;

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       load_out;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign load_out = (state_reg == ST_HOLD) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (accept) begin
                    state_next = stat.need_fetch ? ST_FETCH : ST_HOLD;
                end
            end
            ST_FETCH: begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Read issue at steps 0..4, capture of the registered data at steps 1..5.
    always_comb begin
        cmd.load_item = accept;
        cmd.load_out  = load_out;
        cmd.rd_en     = (state_reg == ST_FETCH) && (step_reg != STEP_LAST);
        cmd.cap_en    = (state_reg == ST_FETCH) && (step_reg != 3'd0);
        case (step_reg)
            3'd0:    cmd.rd_slot = aecb_pkg::SLOT_C;
            3'd1:    cmd.rd_slot = aecb_pkg::SLOT_XM;
            3'd2:    cmd.rd_slot = aecb_pkg::SLOT_XP;
            3'd3:    cmd.rd_slot = aecb_pkg::SLOT_YM;
            default: cmd.rd_slot = aecb_pkg::SLOT_YP;
        endcase
        case (step_reg)
            3'd2:    cmd.cap_slot = aecb_pkg::SLOT_XM;
            3'd3:    cmd.cap_slot = aecb_pkg::SLOT_XP;
            3'd4:    cmd.cap_slot = aecb_pkg::SLOT_YM;
            3'd5:    cmd.cap_slot = aecb_pkg::SLOT_YP;
            default: cmd.cap_slot = aecb_pkg::SLOT_C;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/aecb_datapath.sv @@
module aecb_datapath #(
    parameter int MAX_SIDE = aecb_pkg::MAX_SIDE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [aecb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aecb_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                                s_func,
    input  logic [aecb_pkg::COORD_W-1:0]        s_x_pos,
    input  logic [aecb_pkg::COORD_W-1:0]        s_y_pos,
    input  logic [aecb_pkg::CHAN_W-1:0]         s_red_in,
    input  logic [aecb_pkg::CHAN_W-1:0]         s_green_in,
    input  logic [aecb_pkg::CHAN_W-1:0]         s_blue_in,
    input  logic [aecb_pkg::CHAN_W-1:0]         s_alpha_in,
    output logic [aecb_pkg::CHAN_W-1:0]         m_red_out,
    output logic [aecb_pkg::CHAN_W-1:0]         m_green_out,
    output logic [aecb_pkg::CHAN_W-1:0]         m_blue_out,
    output logic [aecb_pkg::CHAN_W-1:0]         m_alpha_out,
    input  aecb_pkg::cmd_t                      cmd,
    output aecb_pkg::stat_t                     stat
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CW     = (SIDE_W > aecb_pkg::CFG_W) ? SIDE_W : aecb_pkg::CFG_W;
    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW     = aecb_pkg::PIX_W;
    localparam int CH     = aecb_pkg::CHAN_W;

    logic [aecb_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [CW-1:0] w_eff, h_eff, x_in, y_in;
    logic          in_range, do_write;
    logic [PW-1:0] pix_in;

    logic [CW-1:0] x_reg, y_reg, xm_reg, xp_reg, ym_reg, yp_reg;
    logic          xedge_reg, yedge_reg;
    logic [PW-1:0] c_reg, xm_pix_reg, xp_pix_reg, ym_pix_reg, res_reg, out_reg;

    logic [CW-1:0] sel_x, sel_y;
    logic [AW-1:0] wr_addr, rd_addr, ram_addr;
    logic [PW-1:0] rd_data, bleed;
    logic [PW-1:0] h_first, h_second, v_first, v_second;

    function automatic logic opaque(input logic [PW-1:0] px);
        return px[PW-1 -: CH] != '0;
    endfunction

    // Register values out of range are clamped to 1..MAX_SIDE.
    function automatic logic [CW-1:0] clamp_side(input logic [aecb_pkg::CFG_W-1:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        if (ext == '0) begin
            return CW'(1);
        end else if (ext > CW'(MAX_SIDE)) begin
            return CW'(MAX_SIDE);
        end
        return ext;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= aecb_pkg::CFG_SIDE_RESET;
            height_reg <= aecb_pkg::CFG_SIDE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                aecb_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data;
                aecb_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign w_eff    = clamp_side(width_reg);
    assign h_eff    = clamp_side(height_reg);
    assign x_in     = CW'(s_x_pos);
    assign y_in     = CW'(s_y_pos);
    assign in_range = (x_in < w_eff) && (y_in < h_eff);
    assign pix_in   = {s_alpha_in, s_blue_in, s_green_in, s_red_in};
    assign do_write = cmd.load_item && in_range && (s_func == aecb_pkg::FUNC_WRITE);

    assign stat.need_fetch = in_range && (s_func == aecb_pkg::FUNC_READ);

    assign wr_addr = AW'(y_in * MAX_SIDE + x_in);

    always_comb begin
        case (cmd.rd_slot)
            aecb_pkg::SLOT_XM: begin sel_x = xm_reg; sel_y = y_reg;  end
            aecb_pkg::SLOT_XP: begin sel_x = xp_reg; sel_y = y_reg;  end
            aecb_pkg::SLOT_YM: begin sel_x = x_reg;  sel_y = ym_reg; end
            aecb_pkg::SLOT_YP: begin sel_x = x_reg;  sel_y = yp_reg; end
            default:           begin sel_x = x_reg;  sel_y = y_reg;  end
        endcase
    end

    assign rd_addr  = AW'(sel_y * MAX_SIDE + sel_x);
    assign ram_addr = do_write ? wr_addr : rd_addr;

    aecb_ram #(
        .DATA_W (PW),
        .DEPTH  (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .en    (do_write || cmd.rd_en),
        .we    (do_write),
        .addr  (ram_addr),
        .wdata (pix_in),
        .rdata (rd_data)
    );

    // Horizontal neighbors beat vertical ones; at an edge the -1 side comes first.
    assign h_first  = xedge_reg ? xm_pix_reg : xp_pix_reg;
    assign h_second = xedge_reg ? xp_pix_reg : xm_pix_reg;
    assign v_first  = yedge_reg ? ym_pix_reg : rd_data;
    assign v_second = yedge_reg ? rd_data    : ym_pix_reg;

    always_comb begin
        bleed = c_reg;
        if (!opaque(c_reg)) begin
            if (opaque(h_first)) begin
                bleed = {c_reg[PW-1 -: CH], h_first[PW-CH-1:0]};
            end else if (opaque(h_second)) begin
                bleed = {c_reg[PW-1 -: CH], h_second[PW-CH-1:0]};
            end else if (opaque(v_first)) begin
                bleed = {c_reg[PW-1 -: CH], v_first[PW-CH-1:0]};
            end else if (opaque(v_second)) begin
                bleed = {c_reg[PW-1 -: CH], v_second[PW-CH-1:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            x_reg     <= x_in;
            y_reg     <= y_in;
            xm_reg    <= (x_in == '0) ? w_eff - CW'(1) : x_in - CW'(1);
            xp_reg    <= (x_in == w_eff - CW'(1)) ? '0 : x_in + CW'(1);
            ym_reg    <= (y_in == '0) ? h_eff - CW'(1) : y_in - CW'(1);
            yp_reg    <= (y_in == h_eff - CW'(1)) ? '0 : y_in + CW'(1);
            xedge_reg <= (x_in == '0) || (x_in == w_eff - CW'(1));
            yedge_reg <= (y_in == '0) || (y_in == h_eff - CW'(1));
            res_reg   <= do_write ? pix_in : '0;
        end
        if (cmd.cap_en) begin
            case (cmd.cap_slot)
                aecb_pkg::SLOT_C:  c_reg      <= rd_data;
                aecb_pkg::SLOT_XM: xm_pix_reg <= rd_data;
                aecb_pkg::SLOT_XP: xp_pix_reg <= rd_data;
                aecb_pkg::SLOT_YM: ym_pix_reg <= rd_data;
                default:           res_reg    <= bleed;
            endcase
        end
        if (cmd.load_out) begin
            out_reg <= res_reg;
        end
    end

    assign m_red_out   = out_reg[CH-1:0];
    assign m_green_out = out_reg[2*CH-1:CH];
    assign m_blue_out  = out_reg[3*CH-1:2*CH];
    assign m_alpha_out = out_reg[4*CH-1:3*CH];

endmodule

@@ rtl/core/alpha_edge_color_bleed_core.sv @@
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+--------------------------------------------
// s_        | in        | s_valid / s_ready  | s_func, s_x_pos, s_y_pos, s_*_in (RGBA8)
// m_        | out       | m_valid / m_ready  | m_red_out, m_green_out, m_blue_out, m_alpha_out
// cfg_      | in        | cfg_wr_en          | cfg_index, cfg_wr_data
//
// A write, or any item outside the image, takes its transfer and then the load of the output
// register. A read takes its transfer, five fetches from the single-ported memory (center, left,
// right, upper, lower neighbor), a step for the last read data and then the output load.
// Reset clears the control state and sets both size registers to 64; the pixel memory keeps its
// contents and must be written before it is read. A result that is not taken holds in the output
// register; the next item is still accepted, and its result waits until that register frees up.
module alpha_edge_color_bleed_core #(
    parameter int MAX_SIDE = aecb_pkg::MAX_SIDE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Configuration writes, taken on every cycle with cfg_wr_en high.
    input  logic                           cfg_wr_en,
    input  logic [aecb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aecb_pkg::CFG_W-1:0]     cfg_wr_data,

    // Input items.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [aecb_pkg::COORD_W-1:0]   s_x_pos,
    input  logic [aecb_pkg::COORD_W-1:0]   s_y_pos,
    input  logic [aecb_pkg::CHAN_W-1:0]    s_red_in,
    input  logic [aecb_pkg::CHAN_W-1:0]    s_green_in,
    input  logic [aecb_pkg::CHAN_W-1:0]    s_blue_in,
    input  logic [aecb_pkg::CHAN_W-1:0]    s_alpha_in,

    // Result items.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [aecb_pkg::CHAN_W-1:0]    m_red_out,
    output logic [aecb_pkg::CHAN_W-1:0]    m_green_out,
    output logic [aecb_pkg::CHAN_W-1:0]    m_blue_out,
    output logic [aecb_pkg::CHAN_W-1:0]    m_alpha_out
);

    // The controller sequences one item at a time; the datapath holds the size registers,
    // the pixel memory, the fetched neighbors and the output register.
    aecb_pkg::cmd_t  cmd;
    aecb_pkg::stat_t stat;

    aecb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // A write goes into memory in the cycle of its transfer and echoes the stored pixel.
    // A read fetches the center and its four wrapped neighbors and picks the bleed color.
    aecb_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_func      (s_func),
        .s_x_pos     (s_x_pos),
        .s_y_pos     (s_y_pos),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .s_alpha_in  (s_alpha_in),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_alpha_out (m_alpha_out),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

@@ rtl/core/aecb_checker.sv @@
`include "alpha_edge_color_bleed_core_assert.svh"

module aecb_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [aecb_pkg::CHAN_W-1:0] m_red_out,
    input logic [aecb_pkg::CHAN_W-1:0] m_green_out,
    input logic [aecb_pkg::CHAN_W-1:0] m_blue_out,
    input logic [aecb_pkg::CHAN_W-1:0] m_alpha_out
);

    logic [4*aecb_pkg::CHAN_W-1:0] m_pix;

    assign m_pix = {m_alpha_out, m_blue_out, m_green_out, m_red_out};

    // A pending result stays offered.
    `AECB_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready, m_valid)

    // A stalled result keeps its payload.
    `AECB_ASSERT_NEXT(a_out_stable, aclk, !aresetn, m_valid && !m_ready, $stable(m_pix))

    // One item at a time: the input closes right after a transfer.
    `AECB_ASSERT_NEXT(a_one_item, aclk, !aresetn, s_valid && s_ready, !s_ready)

    // Reset leaves no result behind.
    `AECB_ASSERT_NEXT(a_reset_empty, aclk, 1'b0, !aresetn, !m_valid)

endmodule

bind alpha_edge_color_bleed_core aecb_checker u_aecb_checker (.*);
